FILE: rtl/prp_pkg.sv
// Shared constants, types and trig table builder for the point rotate and project block.
package prp_pkg;

  localparam int ANGLE_STEPS = 360;
  localparam int QUARTER_STEPS = ANGLE_STEPS / 4;
  localparam int TAYLOR_TERMS = 12;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Divisors (2k)(2k+1) of the sine series, k = 1..TAYLOR_TERMS.
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ANGLE_X  = 3'd0,
    REG_ANGLE_Y  = 3'd1,
    REG_ANGLE_Z  = 3'd2,
    REG_FOCAL    = 3'd3,
    REG_BIAS     = 3'd4,
    REG_OFFSET_X = 3'd5,
    REG_OFFSET_Y = 3'd6,
    REG_UNUSED   = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
    logic               last;
  } rot_point_t;

  // Quarter-wave sine magnitude of d degrees, rounded to frac fraction bits.
  function automatic longint unsigned quarter_sine(input int d, input int frac);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint sum;
    x = (2 * PI_Q30 * longint'(d) + ANGLE_STEPS / 2) / ANGLE_STEPS;
    x2 = (x * x) >> 30;
    t = x;
    sum = longint'(x);
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      t = (t * x2) >> 30;
      t = t / TAYLOR_DIV[k-1];
      if (k % 2 == 1) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    quarter_sine = (longint'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

endpackage

FILE: rtl/point_rotate_project.sv
// Top level: three-axis vertex rotation and perspective projection pipeline.
//
// Channel  Signals                                   Handshake
// ------   ----------------------------------------  ---------------------------
// vertex   vertex_x/y/z, last_vertex                 start && !busy
// result   rotated_x/y/z, screen_x/y, behind_viewer, done strobe, one cycle
//          last_vertex_out
// config   cfg_index, cfg_data                       cfg_valid && cfg_ready
//
// One vertex is taken every cycle; busy is always low.
// From request to done a vertex passes six rotation stages, two projection
// setup stages, a 27-stage radix-2 restoring divider per axis and the output
// register.
// Reset (rst, synchronous) clears the stage valid bits and loads register defaults.
// The receiver cannot stall, so the pipeline never holds.
module point_rotate_project #(
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [15:0]                    vertex_x,
  input  logic signed [15:0]                    vertex_y,
  input  logic signed [15:0]                    vertex_z,
  input  logic                                  last_vertex,
  output logic                                  done,
  output logic signed [16:0]                    rotated_x,
  output logic signed [16:0]                    rotated_y,
  output logic signed [16:0]                    rotated_z,
  output logic signed [27:0]                    screen_x,
  output logic signed [27:0]                    screen_y,
  output logic                                  behind_viewer,
  output logic                                  last_vertex_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [prp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [prp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int F   = TRIG_FRACTION_BITS;
  localparam int TW  = F + 2;
  localparam int VW  = 18;
  localparam int PW  = VW + TW;
  localparam int SW  = PW + 1;
  localparam int QW  = 27;
  localparam int RW  = 17;
  localparam int LAT = 9 + QW;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // Quarter-wave table, 0..90 degrees.
  logic [F:0] qrom [prp_pkg::QUARTER_STEPS+1];
  for (genvar a = 0; a <= prp_pkg::QUARTER_STEPS; a++) begin : g_qrom
    assign qrom[a] = (F+1)'(prp_pkg::quarter_sine(a, F));
  end

  // Sine and cosine of the angle being written.
  logic [8:0] wr_angle;
  logic [8:0] trig_ang [2];
  logic signed [TW-1:0] trig_val [2];

  always_comb begin
    wr_angle = (cfg_data[8:0] >= 9'(prp_pkg::ANGLE_STEPS))
             ? cfg_data[8:0] - 9'(prp_pkg::ANGLE_STEPS) : cfg_data[8:0];
    trig_ang[0] = wr_angle;
    trig_ang[1] = (wr_angle >= 9'd270) ? wr_angle - 9'd270 : wr_angle + 9'd90;
  end

  for (genvar g = 0; g < 2; g++) begin : g_trig
    logic [6:0] d;
    logic       neg;
    logic signed [TW-1:0] mag;
    always_comb begin
      if (trig_ang[g] < 9'd90) begin
        d = trig_ang[g][6:0];
        neg = 1'b0;
      end else if (trig_ang[g] < 9'd180) begin
        d = 7'(9'd180 - trig_ang[g]);
        neg = 1'b0;
      end else if (trig_ang[g] < 9'd270) begin
        d = 7'(trig_ang[g] - 9'd180);
        neg = 1'b1;
      end else begin
        d = 7'(9'd360 - trig_ang[g]);
        neg = 1'b1;
      end
      mag = $signed({1'b0, qrom[d]});
      trig_val[g] = neg ? -mag : mag;
    end
  end

  localparam logic signed [TW-1:0] ONE = TW'(1) <<< F;

  logic signed [TW-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
  logic [9:0]  focal;
  logic [11:0] bias;
  logic signed [10:0] off_x, off_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      sin_x <= '0; cos_x <= ONE;
      sin_y <= '0; cos_y <= ONE;
      sin_z <= '0; cos_z <= ONE;
      focal <= 10'd100;
      bias  <= 12'd256;
      off_x <= 11'sd100;
      off_y <= 11'sd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (prp_pkg::reg_index_t'(cfg_index))
        prp_pkg::REG_ANGLE_X: begin sin_x <= trig_val[0]; cos_x <= trig_val[1]; end
        prp_pkg::REG_ANGLE_Y: begin sin_y <= trig_val[0]; cos_y <= trig_val[1]; end
        prp_pkg::REG_ANGLE_Z: begin sin_z <= trig_val[0]; cos_z <= trig_val[1]; end
        prp_pkg::REG_FOCAL:    focal <= cfg_data[9:0];
        prp_pkg::REG_BIAS:     bias  <= cfg_data[11:0];
        prp_pkg::REG_OFFSET_X: off_x <= $signed(cfg_data[10:0]);
        prp_pkg::REG_OFFSET_Y: off_y <= $signed(cfg_data[10:0]);
        default: ;
      endcase
    end
  end

  // Divide by 2^F, truncating toward zero.
  function automatic logic signed [VW-1:0] scale(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] b;
    b = s + (s[SW-1] ? {{(SW-F){1'b0}}, {F{1'b1}}} : {SW{1'b0}});
    scale = VW'(b >>> F);
  endfunction

  logic [8:1] v;
  logic       lst [1:6];

  // Rotation about Z.
  logic signed [PW-1:0] p1a, p1b, p1c, p1d;
  logic signed [VW-1:0] z1;
  logic signed [VW-1:0] x2, y2, z2;
  // Rotation about Y.
  logic signed [PW-1:0] p3a, p3b, p3c, p3d;
  logic signed [VW-1:0] y3;
  logic signed [VW-1:0] x4, y4, z4;
  // Rotation about X.
  logic signed [PW-1:0] p5a, p5b, p5c, p5d;
  logic signed [VW-1:0] x5;
  logic signed [VW-1:0] x6, y6, z6;

  logic signed [VW-1:0] ex, ey, ez;
  assign ex = VW'(vertex_x);
  assign ey = VW'(vertex_y);
  assign ez = VW'(vertex_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[7:1], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    lst[1] <= last_vertex;
    for (int i = 2; i <= 6; i++) lst[i] <= lst[i-1];
    p1a <= ex * cos_z; p1b <= ey * sin_z;
    p1c <= ex * sin_z; p1d <= ey * cos_z;
    z1  <= ez;
    x2 <= scale(SW'(p1a) - SW'(p1b));
    y2 <= scale(SW'(p1c) + SW'(p1d));
    z2 <= z1;
    p3a <= x2 * cos_y; p3b <= z2 * sin_y;
    p3c <= z2 * cos_y; p3d <= x2 * sin_y;
    y3  <= y2;
    x4 <= scale(SW'(p3a) + SW'(p3b));
    z4 <= scale(SW'(p3c) - SW'(p3d));
    y4 <= y3;
    p5a <= y4 * cos_x; p5b <= z4 * sin_x;
    p5c <= y4 * sin_x; p5d <= z4 * cos_x;
    x5  <= x4;
    y6 <= scale(SW'(p5a) - SW'(p5b));
    z6 <= scale(SW'(p5c) + SW'(p5d));
    x6 <= x5;
  end

  // Projection setup.
  logic signed [18:0] den7;
  logic signed [28:0] nx7, ny7;
  prp_pkg::rot_point_t pt7, pt8;
  logic [RW-1:0] den8;
  logic [QW-1:0] mx8, my8;
  logic          nsx8, nsy8, beh8;

  always_ff @(posedge clk) begin
    den7 <= 19'(z6) + $signed({9'd0, focal}) + $signed({7'd0, bias});
    nx7  <= x6 * $signed({1'b0, focal});
    ny7  <= y6 * $signed({1'b0, focal});
    pt7  <= '{x: x6[16:0], y: y6[16:0], z: z6[16:0], last: lst[6]};
    pt8  <= pt7;
    den8 <= den7[RW-1:0];
    beh8 <= (den7 <= 19'sd0);
    nsx8 <= nx7[28];
    nsy8 <= ny7[28];
    mx8  <= QW'(nx7[28] ? -nx7 : nx7);
    my8  <= QW'(ny7[28] ? -ny7 : ny7);
  end

  // Restoring divider, one quotient bit per stage. qx and qy shift the numerator out, the quotient in.
  logic                dv   [QW+1];
  prp_pkg::rot_point_t dpt  [QW+1];
  logic [RW-1:0]       dden [QW+1];
  logic                dbeh [QW+1], dnx [QW+1], dny [QW+1];
  logic [RW-1:0]       rx   [QW+1], ry [QW+1];
  logic [QW-1:0]       qx   [QW+1], qy [QW+1];
  logic [RW-1:0]       rx_next [QW], ry_next [QW];
  logic [QW-1:0]       qx_next [QW], qy_next [QW];

  assign dv[0] = v[8];
  assign dpt[0] = pt8;
  assign dden[0] = den8;
  assign dbeh[0] = beh8;
  assign dnx[0] = nsx8;
  assign dny[0] = nsy8;
  assign rx[0] = '0;
  assign ry[0] = '0;
  assign qx[0] = mx8;
  assign qy[0] = my8;

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      logic [RW:0] shx, shy, dfx, dfy;
      shx = {rx[i], qx[i][QW-1]};
      shy = {ry[i], qy[i][QW-1]};
      dfx = shx - {1'b0, dden[i]};
      dfy = shy - {1'b0, dden[i]};
      rx_next[i] = dfx[RW] ? shx[RW-1:0] : dfx[RW-1:0];
      ry_next[i] = dfy[RW] ? shy[RW-1:0] : dfy[RW-1:0];
      qx_next[i] = {qx[i][QW-2:0], !dfx[RW]};
      qy_next[i] = {qy[i][QW-2:0], !dfy[RW]};
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s] <= 1'b0;
      end else begin
        dv[s] <= dv[s-1];
      end
    end
    always_ff @(posedge clk) begin
      dpt[s]  <= dpt[s-1];
      dden[s] <= dden[s-1];
      dbeh[s] <= dbeh[s-1];
      dnx[s]  <= dnx[s-1];
      dny[s]  <= dny[s-1];
      rx[s]   <= rx_next[s-1];
      ry[s]   <= ry_next[s-1];
      qx[s]   <= qx_next[s-1];
      qy[s]   <= qy_next[s-1];
    end
  end

  // Apply sign and offset; drop to zero when behind the viewer.
  logic signed [27:0] sqx, sqy;
  assign sqx = dnx[QW] ? -$signed({1'b0, qx[QW]}) : $signed({1'b0, qx[QW]});
  assign sqy = dny[QW] ? -$signed({1'b0, qy[QW]}) : $signed({1'b0, qy[QW]});

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    rotated_x       <= dpt[QW].x;
    rotated_y       <= dpt[QW].y;
    rotated_z       <= dpt[QW].z;
    last_vertex_out <= dpt[QW].last;
    behind_viewer   <= dbeh[QW];
    screen_x        <= dbeh[QW] ? 28'sd0 : sqx + 28'(off_x);
    screen_y        <= dbeh[QW] ? 28'sd0 : sqy + 28'(off_y);
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request did not produce a result at the pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    (done && behind_viewer) |-> (screen_x == 28'sd0 && screen_y == 28'sd0))
    else $error("screen coordinates not cleared behind viewer");

endmodule
